### rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared constants, controller states and the command/status bundles that
// join the LZSS decoder's controller and datapath.
// ----------------------------------------------------------------------------
package lzss_pkg;

    // Window depth default; the top level parameter takes it from here
    localparam int WINDOW_SIZE_DEF = 4096;

    // Longest copy, also the distance of the reset write pointer from the top
    localparam int MATCH_LIMIT = 18;

    // Shortest copy that a pair encodes
    localparam int MIN_MATCH = 3;

    // Width of the remaining-length counter (0 .. MATCH_LIMIT)
    localparam int LEN_W = $clog2(MATCH_LIMIT + 1);

    // Width of a full offset as the stream encodes it
    localparam int OFFS_W = 12;

    // Upper byte loaded into the flag shifter with every flag byte
    localparam logic [7:0] FLAG_FILL = 8'hff;

    // Controller states
    typedef enum logic [1:0] {
        ST_ITEM,    // expecting a flag byte, a literal or the first byte of a pair
        ST_SECOND,  // expecting the second byte of a pair
        ST_COPY     // issuing window reads for a copy
    } lzss_state_t;

    // Controller to datapath
    typedef struct packed {
        logic lit_load;     // literal transfer: emit and store in_byte
        logic off_load;     // first pair byte: hold low offset
        logic copy_start;   // second pair byte: load read pointer and length
        logic copy_issue;   // issue one window read of the copy
    } lzss_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic p1_valid;     // a read is in flight in the read stage
        logic adv;          // output register can take a byte this cycle
        logic remain_zero;  // all reads of the copy issued
    } lzss_status_t;

endpackage

### rtl/lzss_if.sv
// ----------------------------------------------------------------------------
// lzss_if
// Valid/ready channels of the LZSS decoder: compressed bytes in, plain
// bytes with an end-of-run mark out.
// ----------------------------------------------------------------------------
interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output out_byte, output run_end, input ready);
    modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

### rtl/lzss_ctrl.sv
// ----------------------------------------------------------------------------
// lzss_ctrl
// Controller of the LZSS decoder: item parsing, flag shifter and copy
// sequencing. Drives the datapath through command strobes.
// ----------------------------------------------------------------------------
module lzss_ctrl
    import lzss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    output logic         in_ready,
    input  lzss_status_t status,
    output lzss_cmd_t    cmd
);

    lzss_state_t state_reg, state_next;
    logic [15:0] flag_reg, flag_next;
    logic        acc;

    // State and flag shifter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ITEM;
            flag_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flag_reg  <= flag_next;
        end
    end

    // Input only taken with the read stage drained and the output slot free
    assign in_ready = (state_reg != ST_COPY) && !status.p1_valid && status.adv;
    assign acc      = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        flag_next  = flag_reg;
        cmd        = '0;
        case (state_reg)
            ST_ITEM:
            begin
                if (acc)
                begin
                    if (!flag_reg[8])
                    begin
                        // flag byte: eight item flags, LSB first
                        flag_next = {FLAG_FILL, in_byte};
                    end
                    else
                    begin
                        flag_next = {1'b0, flag_reg[15:1]};
                        if (flag_reg[0])
                        begin
                            cmd.lit_load = 1'b1;
                        end
                        else
                        begin
                            cmd.off_load = 1'b1;
                            state_next   = ST_SECOND;
                        end
                    end
                end
            end
            ST_SECOND:
            begin
                if (acc)
                begin
                    cmd.copy_start = 1'b1;
                    state_next     = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (status.remain_zero)
                begin
                    state_next = ST_ITEM;
                end
                else if (!status.p1_valid || status.adv)
                begin
                    cmd.copy_issue = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_ITEM;
            end
        endcase
    end

endmodule

### rtl/lzss_datapath.sv
// ----------------------------------------------------------------------------
// lzss_datapath
// Datapath of the LZSS decoder: history window memory with registered read,
// read stage with write forwarding, copy pointers and output register.
// ----------------------------------------------------------------------------
module lzss_datapath
    import lzss_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   in_byte,
    input  lzss_cmd_t    cmd,
    output lzss_status_t status,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [7:0]   out_byte,
    output logic         run_end
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam logic [AW-1:0] RESET_POS = AW'(WINDOW_SIZE - MATCH_LIMIT);
    localparam logic [AW:0]   FILL_FULL = (AW+1)'(WINDOW_SIZE);

    // History window
    logic [7:0] win_mem [WINDOW_SIZE];

    logic [7:0]       offs_low_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [LEN_W-1:0] remain_reg;
    logic [AW-1:0]    wp_reg;
    logic [AW:0]      fill_reg;

    logic             p1_valid_reg, p1_valid_next;
    logic             p1_last_reg, p1_last_next;
    logic [AW-1:0]    p1_addr_reg;
    logic             p1_byp_reg;
    logic [7:0]       p1_fwd_reg;
    logic             p1_ok_reg;
    logic [7:0]       rd_data_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             run_end_reg;

    logic             adv;
    logic             p1_take;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic [7:0]       p1_byte;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    rd_rel;
    logic             rd_ok;
    logic [OFFS_W-1:0] offs_full;

    assign adv     = !out_valid_reg || out_ready;
    assign p1_take = p1_valid_reg && adv;

    // Unwritten entries read as zero; forwarded byte wins over the memory
    assign p1_byte = p1_byp_reg ? p1_fwd_reg : (p1_ok_reg ? rd_data_reg : 8'h00);

    assign wr_en   = cmd.lit_load || p1_take;
    assign wr_data = cmd.lit_load ? in_byte : p1_byte;

    // Held read stage re-reads its own address; writes have landed by then
    assign rd_addr = cmd.copy_issue ? rd_ptr_reg : p1_addr_reg;

    // Written entries form one circular run starting at the reset pointer
    assign rd_rel  = rd_addr - RESET_POS;
    assign rd_ok   = {1'b0, rd_rel} < fill_reg;

    assign offs_full = {in_byte[7:4], offs_low_reg};

    // Window memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_mem[wp_reg] <= wr_data;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        p1_addr_reg <= rd_addr;
        p1_byp_reg  <= wr_en && (wp_reg == rd_addr);
        p1_fwd_reg  <= wr_data;
        p1_ok_reg   <= rd_ok;
    end

    // Read stage control
    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        p1_last_next  = p1_last_reg;
        if (cmd.copy_issue)
        begin
            p1_valid_next = 1'b1;
            p1_last_next  = (remain_reg == LEN_W'(1));
        end
        else if (p1_take)
        begin
            p1_valid_next = 1'b0;
        end
    end

    // Copy pointers, write pointer, fill count, read stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offs_low_reg <= '0;
            rd_ptr_reg   <= '0;
            remain_reg   <= '0;
            wp_reg       <= RESET_POS;
            fill_reg     <= '0;
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            p1_last_reg  <= p1_last_next;
            if (cmd.off_load)
            begin
                offs_low_reg <= in_byte;
            end
            if (cmd.copy_start)
            begin
                rd_ptr_reg <= offs_full[AW-1:0];
                remain_reg <= LEN_W'(in_byte[3:0]) + LEN_W'(MIN_MATCH);
            end
            else if (cmd.copy_issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
                remain_reg <= remain_reg - LEN_W'(1);
            end
            if (wr_en)
            begin
                wp_reg <= wp_reg + AW'(1);
                if (fill_reg != FILL_FULL)
                begin
                    fill_reg <= fill_reg + (AW+1)'(1);
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_byte_reg <= wr_data;
            run_end_reg  <= cmd.lit_load ? 1'b1 : p1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;

    assign status.p1_valid    = p1_valid_reg;
    assign status.adv         = adv;
    assign status.remain_zero = (remain_reg == '0);

endmodule

### rtl/lzss_stream_decoder.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decompressor, 4k history window, 12-bit offsets, 4-bit lengths.
// ----------------------------------------------------------------------------
//  Channel  Role    Payload              Meaning
//  comp     sink    in_byte[7:0]         compressed stream, one byte per transfer
//  decomp   source  out_byte[7:0],       decompressed bytes; run_end marks the
//                   run_end              last byte caused by one input byte
//
//  After a second pair byte the next transfer is taken only once the copy
//  is loaded, one window read is issued per copied byte and the read stage
//  has drained. The single read port of the window sets the copy rate of
//  one byte per cycle while decomp is not stalled. Reset is immediate: a
//  fill count makes unwritten window entries read as zero, so no clearing
//  pass is run. A stall on decomp holds the read stage and the copy, and
//  comp stays not ready meanwhile.
// ----------------------------------------------------------------------------
module lzss_stream_decoder
    import lzss_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lzss_in_if.sink     comp,
    lzss_out_if.source  decomp
);

    lzss_cmd_t    cmd;
    lzss_status_t status;

    // Controller
    lzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (comp.valid),
        .in_byte  (comp.in_byte),
        .in_ready (comp.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    lzss_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (comp.in_byte),
        .cmd       (cmd),
        .status    (status),
        .out_ready (decomp.ready),
        .out_valid (decomp.valid),
        .out_byte  (decomp.out_byte),
        .run_end   (decomp.run_end)
    );

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.lit_load, cmd.off_load, cmd.copy_start, cmd.copy_issue}))
        else $error("more than one datapath command in a cycle");

    // No input transfer while a window read is in flight
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (comp.valid && comp.ready) |-> !status.p1_valid)
        else $error("input transfer with read stage busy");

    // An issued read always lands in the read stage
    a_issue_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_issue |=> status.p1_valid)
        else $error("issued read lost");

    // A literal is presented next cycle as a complete run
    a_literal_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lit_load |=> (decomp.valid && decomp.run_end))
        else $error("literal not presented with run end");

endmodule

### test/lzss_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_test
// Self-checking bench for the LZSS stream decoder. Compressed bytes are
// built from flag blocks of literals and back-references, and each
// transfer is decoded by a behavioural model of the 4k window. The plain
// bytes it predicts are checked in order against the decomp channel, with
// random idling on both channels, a long receiver hold-off and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_test
    import lzss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES = 40;    // settle time after the last byte
    localparam int ITEM_TARGET = 350;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } plain_byte_t;

    logic clk;
    logic rst_n;

    lzss_in_if  comp ();
    lzss_out_if decomp ();

    lzss_stream_decoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .comp   (comp),
        .decomp (decomp)
    );

    // Decoder model state
    logic [7:0]  hist [WINDOW_SIZE_DEF];
    logic [11:0] wr_ptr;
    logic [15:0] flag_bits;
    logic        pair_pending;
    logic [7:0]  pair_low;

    plain_byte_t plain_queue [$];

    // Stimulus control
    logic [11:0] gen_pos;       // write position as the stream builder sees it
    int          tx_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_req;
    logic        quiet;
    int          stall_cycles;
    int          errors;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic void push_plain(input logic [7:0] data, input logic last);
        plain_byte_t pb;
        pb.data = data;
        pb.last = last;
        plain_queue.push_back(pb);
        hist[wr_ptr] = data;
        wr_ptr = wr_ptr + 12'd1;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < WINDOW_SIZE_DEF; i++)
            hist[i] = 8'h00;
        wr_ptr       = 12'(WINDOW_SIZE_DEF - MATCH_LIMIT);
        flag_bits    = '0;
        pair_pending = 1'b0;
        pair_low     = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [11:0] rd;
        int          run_len;
        logic        lit;
        if (pair_pending)
        begin
            // second pair byte: copy one byte at a time so overlaps repeat
            rd           = {b[7:4], pair_low};
            run_len      = int'(b[3:0]) + MIN_MATCH;
            pair_pending = 1'b0;
            for (int k = 0; k < run_len; k++)
            begin
                push_plain(hist[rd], k == run_len - 1);
                rd = rd + 12'd1;
            end
        end
        else if (!flag_bits[8])
        begin
            flag_bits = {FLAG_FILL, b};
        end
        else
        begin
            lit       = flag_bits[0];
            flag_bits = flag_bits >> 1;
            if (lit)
                push_plain(b, 1'b1);
            else
            begin
                pair_low     = b;
                pair_pending = 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: check decomp transfers, then decode comp transfers
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic        moved;
        plain_byte_t want;
        moved = 1'b0;
        if (rst_n)
        begin
            if (decomp.valid && decomp.ready)
            begin
                moved = 1'b1;
                if (plain_queue.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %02h run_end %0b",
                           decomp.out_byte, decomp.run_end);
                    errors++;
                end
                else
                begin
                    want = plain_queue.pop_front();
                    if (decomp.out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.data, decomp.out_byte);
                        errors++;
                    end
                    if (decomp.run_end !== want.last)
                    begin
                        $error("run_end: expected %0b, got %0b",
                               want.last, decomp.run_end);
                        errors++;
                    end
                end
            end
            if (comp.valid && comp.ready)
            begin
                moved = 1'b1;
                decode_byte(comp.in_byte);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        int hold_left;
        int stall_left;
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            decomp.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            decomp.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < rx_idle_pct)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            decomp.ready <= 1'b0;
        end
        else
            decomp.ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 8);
            comp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        comp.valid   <= 1'b1;
        comp.in_byte <= b;
        do
            @(posedge clk);
        while (!comp.ready);
        tx_count++;
    endtask

    task automatic send_literal(input logic [7:0] b);
        send_byte(b);
        gen_pos = gen_pos + 12'd1;
    endtask

    task automatic send_pair(input logic [11:0] src, input logic [3:0] len_code);
        send_byte(src[7:0]);
        send_byte({src[11:8], len_code});
        gen_pos = gen_pos + 12'(len_code) + 12'(MIN_MATCH);
    endtask

    // Stop sending and wait until every predicted byte has been seen
    task automatic wait_for_drain();
        comp.valid <= 1'b0;
        @(posedge clk);
        while (plain_queue.size() != 0)
            @(posedge clk);
    endtask

    // Mostly recent history, some short overlapping distances, some anywhere
    function automatic logic [11:0] random_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return gen_pos - 12'($urandom_range(1, 40));
        else if (r < 80)
            return gen_pos - 12'($urandom_range(1, 3));
        else
            return 12'($urandom);
    endfunction

    // One flag byte and its eight items
    task automatic send_random_block(input int lit_pct, input logic long_copies);
        logic [7:0] fl;
        for (int i = 0; i < 8; i++)
            fl[i] = ($urandom_range(0, 99) < lit_pct);
        send_byte(fl);
        for (int i = 0; i < 8; i++)
        begin
            if (fl[i])
                send_literal(8'($urandom));
            else
                send_pair(random_offset(),
                          long_copies ? 4'hf : 4'($urandom_range(0, 15)));
        end
    endtask

    // After a drain, pick up the parse where the model stands and finish the block
    task automatic resync_stream();
        logic [15:0] fl;
        logic [7:0]  b;
        wait_for_drain();
        gen_pos = wr_ptr;
        fl      = flag_bits;
        if (pair_pending)
        begin
            b = 8'($urandom);
            send_byte(b);
            gen_pos = gen_pos + 12'(b[3:0]) + 12'(MIN_MATCH);
        end
        while (fl[8])
        begin
            if (fl[0])
                send_literal(8'($urandom));
            else
                send_pair(random_offset(), 4'($urandom_range(0, 15)));
            fl = fl >> 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Eight literals: edges of the byte range and alternating bit patterns
    task automatic test_literals();
        send_byte(8'hff);
        send_literal(8'h00);
        send_literal(8'hff);
        send_literal(8'h55);
        send_literal(8'haa);
        send_literal(8'h01);
        send_literal(8'h80);
        send_literal(8'h7f);
        send_literal(8'hfe);
    endtask

    // Copies: untouched window, recent literals, overlaps, wrap at the top
    task automatic test_copies();
        send_byte(8'hc0);
        send_pair(12'h000, 4'h0);               // never written, reads zero
        send_pair(12'(WINDOW_SIZE_DEF - MATCH_LIMIT), 4'h5);
        send_pair(gen_pos - 12'd1, 4'hf);       // single byte repeated
        send_pair(gen_pos - 12'd2, 4'hf);       // two-byte pattern repeated
        send_pair(12'hfff, 4'h1);               // source wraps past the top
        send_pair(12'hf0e, 4'ha);
        send_literal(8'h3c);
        send_literal(8'hc3);
    endtask

    // Stream stopped after a flag byte, then after the first pair byte
    task automatic test_truncation();
        send_byte(8'hfe);
        wait_for_drain();
        send_byte(8'($urandom));
        wait_for_drain();
        resync_stream();
    endtask

    // Receiver holds off while the sender keeps offering long copies
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = HOLD_CYCLES;
        repeat (3) send_random_block(25, 1'b1);
        wait_for_drain();
    endtask

    // Random blocks with idling, some noise bytes in between
    task automatic test_random_stream();
        while (tx_count < ITEM_TARGET - 60)
        begin
            tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
                resync_stream();
            end
            else
                send_random_block($urandom_range(0, 3) == 0 ? 80 : 50, 1'b0);
        end
        wait_for_drain();
    endtask

    // Final stretch with no idling on either side
    task automatic test_full_rate();
        quiet = 1'b1;
        while (tx_count < ITEM_TARGET)
            send_random_block(50, 1'b0);
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        comp.valid     = 1'b0;
        comp.in_byte   = 8'h00;
        decomp.ready   = 1'b0;
        tx_count       = 0;
        tx_idle_pct    = 20;
        rx_idle_pct    = 20;
        hold_req       = 0;
        quiet          = 1'b0;
        stall_cycles   = 0;
        errors         = 0;
        clear_model();
        gen_pos        = wr_ptr;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literals();
        test_copies();
        test_truncation();
        test_backpressure();
        test_random_stream();
        test_full_rate();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
